### hw/rtl/qss_pkg.sv
package qss_pkg;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_NAME_END = 2'd1,
		KIND_PAIR_END = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ESC_IDLE    = 2'd0,
		ESC_PERCENT = 2'd1,
		ESC_DIGIT   = 2'd2
	} esc_t;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ASSIGN_LO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ASSIGN_HI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_HI  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_LO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_HI  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 3'd6;

	localparam logic [63:0] ASSIGN_LO_RST = 64'h2000_0000_0000_0000;
	localparam logic [63:0] DELIM_LO_RST  = 64'h0800_0040_0000_0000;
	localparam logic [63:0] SPACE_LO_RST  = 64'h0000_0001_0000_2600;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_LA      = 8'h61;
	localparam logic [7:0] CHAR_LF      = 8'h66;
	localparam logic [7:0] CHAR_UA      = 8'h41;
	localparam logic [7:0] CHAR_UF      = 8'h46;

	localparam int unsigned MAX_RES = 4;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        had;
		logic        tend;
	} res_t;

	typedef struct packed {
		logic [1:0]              last_idx;
		res_t [MAX_RES-1:0]      r;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

### hw/rtl/query_string_splitter_top.sv
// path: an accepted item is written to the bundle queue, then loaded into the result register
// throughput: one item per cycle while results are popped, the bundle queue is not full and
// each item yields at most one result; an item's k results hold the port until popped
// reset: escape and pair state cleared, character sets and raw mode return to defaults,
// queue and result register emptied
module query_string_splitter_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    text_byte,
	input  logic                          text_last,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    kind,
	output logic [7:0]                    data_byte,
	output logic                          had_name,
	output logic                          run_end,
	output logic                          text_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	qss_pkg::q_status_t q_status;
	qss_pkg::bundle_t   q_wr_data, q_rd_data;
	logic               q_wr, q_rd;

	assign full = q_status.full;

	qss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text_byte (text_byte),
		.text_last (text_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.q_wr      (q_wr),
		.q_wr_data (q_wr_data)
	);

	qss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	qss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_rd_data (q_rd_data),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.data_byte (data_byte),
		.had_name  (had_name),
		.run_end   (run_end),
		.text_end  (text_end)
	);

endmodule

### hw/rtl/qss_front.sv
module qss_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic [7:0]                           text_byte,
	input  logic                                 text_last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [qss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [63:0]                          cfg_data,
	input  qss_pkg::q_status_t                   q_status,
	output logic                                 q_wr,
	output qss_pkg::bundle_t                     q_wr_data
);

	typedef struct packed {
		logic          in_name;
		logic          skip;
		logic          set_esc;
		logic          emit;
		qss_pkg::res_t res;
	} plain_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] val;
	} hex_t;

	logic [63:0] assign_lo_q, assign_hi_q, delim_lo_q, delim_hi_q, space_lo_q, space_hi_q;
	logic        raw_mode_q;
	logic [127:0] assign_set, delim_set, space_set;

	qss_pkg::esc_t esc_q, esc_n;
	logic [7:0]    held_q, held_n;
	logic          in_name_q, in_name_n;
	logic          skip_q, skip_n;

	logic             accept;
	logic [2:0]       n;
	qss_pkg::bundle_t bundle;

	assign assign_set = {assign_hi_q, assign_lo_q};
	assign delim_set  = {delim_hi_q, delim_lo_q};
	assign space_set  = {space_hi_q, space_lo_q};

	function automatic logic member(input logic [127:0] set, input logic [7:0] c);
		return !c[7] && set[c[6:0]];
	endfunction

	function automatic hex_t hex_fn(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c inside {[qss_pkg::CHAR_0:qss_pkg::CHAR_9]}) begin
			h.valid = 1'b1;
			h.val   = c[3:0];
		end else if (c inside {[qss_pkg::CHAR_LA:qss_pkg::CHAR_LF],
				[qss_pkg::CHAR_UA:qss_pkg::CHAR_UF]}) begin
			h.valid = 1'b1;
			h.val   = 4'(c[3:0] + 4'd9);
		end
		return h;
	endfunction

	function automatic qss_pkg::res_t data_res(input logic [7:0] c);
		qss_pkg::res_t r;
		r      = '0;
		r.kind = qss_pkg::KIND_DATA;
		r.data = c;
		return r;
	endfunction

	function automatic plain_t plain_fn(input logic [7:0] c, input logic in_name,
			input logic skip, input logic raw, input logic [127:0] aset,
			input logic [127:0] dset, input logic [127:0] sset);
		plain_t p;
		p         = '0;
		p.in_name = in_name;
		p.skip    = skip;
		if (!(skip && member(sset, c))) begin
			p.skip = 1'b0;
			if (member(aset, c)) begin
				if (in_name) begin
					p.in_name  = 1'b0;
					p.emit     = 1'b1;
					p.res.kind = qss_pkg::KIND_NAME_END;
				end
			end else if (member(dset, c)) begin
				p.emit     = 1'b1;
				p.res.kind = qss_pkg::KIND_PAIR_END;
				p.res.had  = !in_name;
				p.in_name  = 1'b1;
				p.skip     = 1'b1;
			end else if (raw) begin
				p.emit = 1'b1;
				p.res  = data_res(c);
			end else if (c == qss_pkg::CHAR_PERCENT) begin
				p.set_esc = 1'b1;
			end else if (c == qss_pkg::CHAR_PLUS) begin
				p.emit = 1'b1;
				p.res  = data_res(qss_pkg::CHAR_SPACE);
			end else begin
				p.emit = 1'b1;
				p.res  = data_res(c);
			end
		end
		return p;
	endfunction

	// item classification and result expansion
	always_comb begin
		plain_t pr;
		hex_t   hc, hh;
		pr        = '0;
		hc        = hex_fn(text_byte);
		hh        = hex_fn(held_q);
		n         = 3'd0;
		bundle    = '0;
		esc_n     = qss_pkg::ESC_IDLE;
		held_n    = held_q;
		in_name_n = in_name_q;
		skip_n    = skip_q;
		case (esc_q)
			qss_pkg::ESC_PERCENT: begin
				if (hc.valid) begin
					held_n = text_byte;
					esc_n  = qss_pkg::ESC_DIGIT;
				end else begin
					bundle.r[n[1:0]] = data_res(qss_pkg::CHAR_PERCENT);
					n = n + 3'd1;
					pr = plain_fn(text_byte, in_name_n, skip_n, raw_mode_q,
						assign_set, delim_set, space_set);
					if (pr.emit) begin
						bundle.r[n[1:0]] = pr.res;
						n = n + 3'd1;
					end
					in_name_n = pr.in_name;
					skip_n    = pr.skip;
					if (pr.set_esc) esc_n = qss_pkg::ESC_PERCENT;
				end
			end
			qss_pkg::ESC_DIGIT: begin
				if (hc.valid) begin
					bundle.r[n[1:0]] = data_res({hh.val, hc.val});
					n = n + 3'd1;
				end else begin
					bundle.r[n[1:0]] = data_res(qss_pkg::CHAR_PERCENT);
					n = n + 3'd1;
					pr = plain_fn(held_q, in_name_n, skip_n, raw_mode_q,
						assign_set, delim_set, space_set);
					if (pr.emit) begin
						bundle.r[n[1:0]] = pr.res;
						n = n + 3'd1;
					end
					in_name_n = pr.in_name;
					skip_n    = pr.skip;
					pr = plain_fn(text_byte, in_name_n, skip_n, raw_mode_q,
						assign_set, delim_set, space_set);
					if (pr.emit) begin
						bundle.r[n[1:0]] = pr.res;
						n = n + 3'd1;
					end
					in_name_n = pr.in_name;
					skip_n    = pr.skip;
					if (pr.set_esc) esc_n = qss_pkg::ESC_PERCENT;
				end
			end
			default: begin
				pr = plain_fn(text_byte, in_name_n, skip_n, raw_mode_q,
					assign_set, delim_set, space_set);
				if (pr.emit) begin
					bundle.r[n[1:0]] = pr.res;
					n = n + 3'd1;
				end
				in_name_n = pr.in_name;
				skip_n    = pr.skip;
				if (pr.set_esc) esc_n = qss_pkg::ESC_PERCENT;
			end
		endcase
		if (text_last) begin
			// short escape at end of text
			if (esc_n == qss_pkg::ESC_PERCENT || esc_n == qss_pkg::ESC_DIGIT) begin
				bundle.r[n[1:0]] = data_res(qss_pkg::CHAR_PERCENT);
				n = n + 3'd1;
				if (esc_n == qss_pkg::ESC_DIGIT) begin
					pr = plain_fn(held_n, in_name_n, skip_n, raw_mode_q,
						assign_set, delim_set, space_set);
					if (pr.emit) begin
						bundle.r[n[1:0]] = pr.res;
						n = n + 3'd1;
					end
					in_name_n = pr.in_name;
				end
			end
			bundle.r[n[1:0]].kind = qss_pkg::KIND_PAIR_END;
			bundle.r[n[1:0]].had  = !in_name_n;
			bundle.r[n[1:0]].tend = 1'b1;
			n = n + 3'd1;
			esc_n     = qss_pkg::ESC_IDLE;
			in_name_n = 1'b1;
			skip_n    = 1'b0;
			held_n    = 8'd0;
		end
		bundle.last_idx = 2'(n - 3'd1);
	end

	assign accept    = push && !q_status.full;
	assign q_wr      = accept && (n != 3'd0);
	assign q_wr_data = bundle;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= qss_pkg::ESC_IDLE;
			held_q    <= 8'd0;
			in_name_q <= 1'b1;
			skip_q    <= 1'b0;
		end else if (accept) begin
			esc_q     <= esc_n;
			held_q    <= held_n;
			in_name_q <= in_name_n;
			skip_q    <= skip_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assign_lo_q <= qss_pkg::ASSIGN_LO_RST;
			assign_hi_q <= 64'd0;
			delim_lo_q  <= qss_pkg::DELIM_LO_RST;
			delim_hi_q  <= 64'd0;
			space_lo_q  <= qss_pkg::SPACE_LO_RST;
			space_hi_q  <= 64'd0;
			raw_mode_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qss_pkg::CFG_ASSIGN_LO: assign_lo_q <= cfg_data;
				qss_pkg::CFG_ASSIGN_HI: assign_hi_q <= cfg_data;
				qss_pkg::CFG_DELIM_LO:  delim_lo_q  <= cfg_data;
				qss_pkg::CFG_DELIM_HI:  delim_hi_q  <= cfg_data;
				qss_pkg::CFG_SPACE_LO:  space_lo_q  <= cfg_data;
				qss_pkg::CFG_SPACE_HI:  space_hi_q  <= cfg_data;
				qss_pkg::CFG_RAW_MODE:  raw_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/qss_queue.sv
module qss_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  qss_pkg::bundle_t   wr_data,
	input  logic               rd,
	output qss_pkg::bundle_t   rd_data,
	output qss_pkg::q_status_t status
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	qss_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign status.full      = (cnt_q == CW'(DEPTH));
	assign status.not_empty = (cnt_q != '0);
	assign rd_data          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (wr && !rd) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (rd && !wr) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

### hw/rtl/qss_back.sv
module qss_back (
	input  logic               clk,
	input  logic               arst_n,
	input  qss_pkg::q_status_t q_status,
	input  qss_pkg::bundle_t   q_rd_data,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         kind,
	output logic [7:0]         data_byte,
	output logic               had_name,
	output logic               run_end,
	output logic               text_end
);

	qss_pkg::bundle_t bundle_q;
	logic [1:0]       idx_q;
	logic             valid_q;
	logic             at_last;
	qss_pkg::res_t    cur;

	assign at_last = (idx_q == bundle_q.last_idx);
	assign q_rd    = q_status.not_empty && (!valid_q || (pop && at_last));
	assign cur     = bundle_q.r[idx_q];

	assign empty     = !valid_q;
	assign kind      = cur.kind;
	assign data_byte = cur.data;
	assign had_name  = cur.had;
	assign text_end  = cur.tend;
	assign run_end   = at_last;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			bundle_q <= q_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (pop && valid_q) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= 2'(idx_q + 2'd1);
			end
		end
	end

endmodule
